[design/apq_pkg.sv]
package apq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int TAG_W       = 16;
    localparam int PRIO_W      = 3;
    localparam int TIME_W      = 32;
    localparam int FILL_W      = 5;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CNT_W-1:0]  FULL_CNT        = CNT_W'(QUEUE_DEPTH);
    localparam logic [TIME_W-1:0] THRESHOLD_RESET = TIME_W'(1000);
    localparam logic [PRIO_W-1:0] FREE_RESET      = PRIO_W'(0);
    localparam logic [PRIO_W-1:0] PREMIUM_RESET   = PRIO_W'(1);

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_TICK_DONE = 3'd0,
        STAT_PUSHED    = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_POPPED    = 3'd3,
        STAT_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_FREE      = 2'd1,
        CFG_PREMIUM   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_POP
    } bk_state_t;

    typedef struct packed {
        op_t               kind;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
        logic [FILL_W-1:0] fill;
    } res_t;

    function automatic logic [FILL_W-1:0] fill_of(input logic [CNT_W-1:0] cnt);
        fill_of = FILL_W'(cnt);
    endfunction

    function automatic logic [IDX_W-1:0] idx_of_cnt(input logic [CNT_W-1:0] cnt);
        idx_of_cnt = IDX_W'(cnt);
    endfunction

    function automatic logic [IDX_W-1:0] idx_of_int(input int unsigned v);
        idx_of_int = IDX_W'(v);
    endfunction

endpackage

[design/apq_front.sv]
module apq_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  op,
    input  logic [apq_pkg::TAG_W-1:0]   job_tag,
    input  logic [apq_pkg::PRIO_W-1:0]  job_priority,
    output logic                        cmd_valid,
    output apq_pkg::cmd_t               cmd,
    input  logic                        cmd_take
);

    apq_pkg::cmd_t slot0_reg, slot0_next;
    apq_pkg::cmd_t slot1_reg, slot1_next;
    logic [1:0]    cnt_reg, cnt_next;
    apq_pkg::cmd_t word_in;
    logic          accept;
    logic          take;

    // classify the incoming word
    always_comb
    begin
        word_in.kind = apq_pkg::op_t'(op);
        word_in.tag  = job_tag;
        word_in.prio = job_priority;
    end

    assign full      = (cnt_reg == 2'd2);
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign take      = cmd_take && cmd_valid;
    assign cmd       = slot0_reg;

    always_comb
    begin
        slot0_next = take ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg + {1'b0, accept} - {1'b0, take};
        if (accept)
        begin
            if ((cnt_reg - {1'b0, take}) == 2'd0)
            begin
                slot0_next = word_in;
            end
            else
            begin
                slot1_next = word_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

[design/apq_back.sv]
module apq_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [apq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [apq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            cmd_valid,
    input  apq_pkg::cmd_t                   cmd,
    output logic                            cmd_take,
    input  logic                            res_space,
    output logic                            res_write,
    output apq_pkg::res_t                   res_word
);

    apq_pkg::bk_state_t state_reg, state_next;

    logic [apq_pkg::TAG_W-1:0]  tags_reg   [apq_pkg::QUEUE_DEPTH];
    logic [apq_pkg::PRIO_W-1:0] prios_reg  [apq_pkg::QUEUE_DEPTH];
    logic [apq_pkg::TIME_W-1:0] stamps_reg [apq_pkg::QUEUE_DEPTH];

    logic [apq_pkg::CNT_W-1:0]  count_reg;
    logic [apq_pkg::TIME_W-1:0] time_reg;
    logic [apq_pkg::TIME_W-1:0] thr_reg;
    logic [apq_pkg::PRIO_W-1:0] free_reg;
    logic [apq_pkg::PRIO_W-1:0] prem_reg;

    logic [apq_pkg::CNT_W-1:0]  scan_reg;
    logic [apq_pkg::IDX_W-1:0]  best_reg;
    logic [apq_pkg::PRIO_W-1:0] best_code_reg;

    logic [apq_pkg::IDX_W-1:0]  scan_idx;
    logic [apq_pkg::PRIO_W-1:0] scan_code;
    logic [apq_pkg::TIME_W-1:0] scan_age;
    logic                       scan_last;

    logic tick_en;
    logic push_en;
    logic start_scan;
    logic scan_step;
    logic pop_en;

    // effective code of the entry under the scan pointer
    always_comb
    begin
        scan_idx  = apq_pkg::idx_of_cnt(scan_reg);
        scan_age  = time_reg - stamps_reg[scan_idx];
        scan_code = prios_reg[scan_idx];
        if ((prios_reg[scan_idx] == free_reg) && (scan_age >= thr_reg))
        begin
            scan_code = prem_reg;
        end
    end

    assign scan_last = (scan_reg == (count_reg - 1'b1));

    // outputs
    always_comb
    begin
        cmd_take   = 1'b0;
        res_write  = 1'b0;
        tick_en    = 1'b0;
        push_en    = 1'b0;
        start_scan = 1'b0;
        scan_step  = 1'b0;
        pop_en     = 1'b0;
        res_word.status = apq_pkg::STAT_TICK_DONE;
        res_word.tag    = '0;
        res_word.prio   = '0;
        res_word.fill   = apq_pkg::fill_of(count_reg);
        unique case (state_reg)
            apq_pkg::BK_IDLE:
            begin
                if (cmd_valid && res_space)
                begin
                    cmd_take = 1'b1;
                    case (cmd.kind)
                        apq_pkg::OP_TICK:
                        begin
                            tick_en   = 1'b1;
                            res_write = 1'b1;
                        end
                        apq_pkg::OP_PUSH:
                        begin
                            res_write = 1'b1;
                            if (count_reg >= apq_pkg::FULL_CNT)
                            begin
                                res_word.status = apq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                push_en         = 1'b1;
                                res_word.status = apq_pkg::STAT_PUSHED;
                                res_word.fill   = apq_pkg::fill_of(count_reg + 1'b1);
                            end
                        end
                        apq_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_write       = 1'b1;
                                res_word.status = apq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                start_scan = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_write = 1'b1;
                        end
                    endcase
                end
            end
            apq_pkg::BK_SCAN:
            begin
                scan_step = 1'b1;
            end
            apq_pkg::BK_POP:
            begin
                pop_en          = 1'b1;
                res_write       = 1'b1;
                res_word.status = apq_pkg::STAT_POPPED;
                res_word.tag    = tags_reg[best_reg];
                res_word.prio   = prios_reg[best_reg];
                res_word.fill   = apq_pkg::fill_of(count_reg - 1'b1);
            end
            default:
            begin
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            apq_pkg::BK_IDLE:
            begin
                if (start_scan)
                begin
                    state_next = apq_pkg::BK_SCAN;
                end
            end
            apq_pkg::BK_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = apq_pkg::BK_POP;
                end
            end
            apq_pkg::BK_POP:
            begin
                state_next = apq_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = apq_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= apq_pkg::BK_IDLE;
            count_reg <= '0;
            time_reg  <= '0;
            thr_reg   <= apq_pkg::THRESHOLD_RESET;
            free_reg  <= apq_pkg::FREE_RESET;
            prem_reg  <= apq_pkg::PREMIUM_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (tick_en)
            begin
                time_reg <= time_reg + 1'b1;
            end
            if (push_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    apq_pkg::CFG_THRESHOLD: thr_reg  <= cfg_data;
                    apq_pkg::CFG_FREE:      free_reg <= cfg_data[apq_pkg::PRIO_W-1:0];
                    apq_pkg::CFG_PREMIUM:   prem_reg <= cfg_data[apq_pkg::PRIO_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // scan pointer and running best
    always_ff @(posedge clk)
    begin
        if (start_scan)
        begin
            scan_reg <= '0;
        end
        else if (scan_step)
        begin
            scan_reg <= scan_reg + 1'b1;
            if ((scan_reg == '0) || (scan_code > best_code_reg))
            begin
                best_reg      <= scan_idx;
                best_code_reg <= scan_code;
            end
        end
    end

    // entry store: append at the tail, close the gap on removal
    always_ff @(posedge clk)
    begin
        for (int unsigned i = 0; i < apq_pkg::QUEUE_DEPTH; i++)
        begin
            if (push_en && (apq_pkg::idx_of_cnt(count_reg) == apq_pkg::idx_of_int(i)))
            begin
                tags_reg[i]   <= cmd.tag;
                prios_reg[i]  <= cmd.prio;
                stamps_reg[i] <= time_reg;
            end
        end
        for (int unsigned i = 0; i + 1 < apq_pkg::QUEUE_DEPTH; i++)
        begin
            if (pop_en && (apq_pkg::idx_of_int(i) >= best_reg))
            begin
                tags_reg[i]   <= tags_reg[i + 1];
                prios_reg[i]  <= prios_reg[i + 1];
                stamps_reg[i] <= stamps_reg[i + 1];
            end
        end
    end

endmodule

[design/apq_res_fifo.sv]
module apq_res_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  apq_pkg::res_t wr_word,
    output logic          space,
    input  logic          pop,
    output logic          empty,
    output apq_pkg::res_t head
);

    apq_pkg::res_t slot0_reg, slot0_next;
    apq_pkg::res_t slot1_reg, slot1_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          rd;

    assign empty = (cnt_reg == 2'd0);
    assign space = (cnt_reg != 2'd2);
    assign rd    = pop && !empty;
    assign head  = slot0_reg;

    always_comb
    begin
        slot0_next = rd ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg + {1'b0, wr} - {1'b0, rd};
        if (wr)
        begin
            if ((cnt_reg - {1'b0, rd}) == 2'd0)
            begin
                slot0_next = wr_word;
            end
            else
            begin
                slot1_next = wr_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

[design/aging_priority_queue.sv]
// channel   direction  handshake         word
// input     in         push / full       op, job_tag, job_priority
// result    out        empty / pop       status, out_tag, out_priority, fill_count
// config    in         cfg_we            cfg_index, cfg_data
//
// tick, push and unused op are answered straight from the idle state of the back end
// pop on a non-empty queue goes through a scan state and a pop state: one comparator walks every held entry
// reset empties the queue, clears the time counter, threshold 1000, free 0, premium 1
// two-word input queue and two-word result queue let either side stall alone
module aging_priority_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      op,
    input  logic [apq_pkg::TAG_W-1:0]       job_tag,
    input  logic [apq_pkg::PRIO_W-1:0]      job_priority,
    output logic                            empty,
    input  logic                            pop,
    output logic [2:0]                      status,
    output logic [apq_pkg::TAG_W-1:0]       out_tag,
    output logic [apq_pkg::PRIO_W-1:0]      out_priority,
    output logic [apq_pkg::FILL_W-1:0]      fill_count,
    input  logic                            cfg_we,
    input  logic [apq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [apq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic          cmd_valid;
    logic          cmd_take;
    apq_pkg::cmd_t cmd;
    logic          res_space;
    logic          res_write;
    apq_pkg::res_t res_word;
    apq_pkg::res_t head;

    apq_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .op           (op),
        .job_tag      (job_tag),
        .job_priority (job_priority),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (cmd_take)
    );

    apq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_space (res_space),
        .res_write (res_write),
        .res_word  (res_word)
    );

    apq_res_fifo u_res (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_write),
        .wr_word (res_word),
        .space   (res_space),
        .pop     (pop),
        .empty   (empty),
        .head    (head)
    );

    assign status       = head.status;
    assign out_tag      = head.tag;
    assign out_priority = head.prio;
    assign fill_count   = head.fill;

`ifndef SYNTHESIS
    a_empty_status_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == apq_pkg::STAT_EMPTY)) |-> (fill_count == '0))
        else $error("empty status with entries held");

    a_pushed_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == apq_pkg::STAT_PUSHED)) |-> (fill_count != '0))
        else $error("push reported with no entry held");

    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == apq_pkg::STAT_FULL))
            |-> (fill_count == apq_pkg::fill_of(apq_pkg::FULL_CNT)))
        else $error("full rejection below depth");

    a_popped_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != apq_pkg::STAT_POPPED)) |-> (out_tag == '0))
        else $error("tag on a word that is not a pop");
`endif

endmodule

[test/aging_priority_queue_test.sv]
`timescale 1ns / 1ps

module aging_priority_queue_test;
    import apq_pkg::*;

    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_WORDS    = 190;
    localparam int PHASES         = 6;
    localparam int PLAN_ROWS      = 17;

    localparam logic [TIME_W-1:0] PHASE_THRESHOLD [PHASES] =
        '{32'd0, 32'hFFFF_FFFF, 32'd5, 32'd12, 32'd2, 32'd8};
    localparam logic [PRIO_W-1:0] PHASE_FREE [PHASES]    = '{3'd0, 3'd7, 3'd5, 3'd1, 3'd3, 3'd2};
    localparam logic [PRIO_W-1:0] PHASE_PREMIUM [PHASES] = '{3'd7, 3'd0, 3'd2, 3'd6, 3'd3, 3'd0};
    localparam int PHASE_SEND_IDLE [PHASES] = '{32, 32, 60, 60, 0, 0};
    localparam int PHASE_RECV_IDLE [PHASES] = '{60, 60, 32, 32, 0, 0};

    typedef struct packed {
        op_t               kind;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
        logic [4:0]        reps;
        logic              fixed;
        res_t              reply;
    } plan_row_t;

    // default settings: threshold 1000, free 0, premium 1, so nothing ages here
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{OP_POP,  16'h0000, 3'd0, 5'd1,  1'b1, '{STAT_EMPTY,     16'h0000, 3'd0, 5'd0}},
        '{OP_NONE, 16'hFFFF, 3'd7, 5'd1,  1'b1, '{STAT_TICK_DONE, 16'h0000, 3'd0, 5'd0}},
        '{OP_TICK, 16'h0000, 3'd0, 5'd1,  1'b1, '{STAT_TICK_DONE, 16'h0000, 3'd0, 5'd0}},
        '{OP_PUSH, 16'hFFFF, 3'd7, 5'd1,  1'b1, '{STAT_PUSHED,    16'h0000, 3'd0, 5'd1}},
        '{OP_PUSH, 16'h0000, 3'd0, 5'd1,  1'b1, '{STAT_PUSHED,    16'h0000, 3'd0, 5'd2}},
        '{OP_PUSH, 16'hA5A5, 3'd0, 5'd1,  1'b1, '{STAT_PUSHED,    16'h0000, 3'd0, 5'd3}},
        '{OP_PUSH, 16'h5A5A, 3'd3, 5'd1,  1'b1, '{STAT_PUSHED,    16'h0000, 3'd0, 5'd4}},
        '{OP_POP,  16'h0000, 3'd0, 5'd1,  1'b1, '{STAT_POPPED,    16'hFFFF, 3'd7, 5'd3}},
        '{OP_POP,  16'h0000, 3'd0, 5'd1,  1'b1, '{STAT_POPPED,    16'h5A5A, 3'd3, 5'd2}},
        '{OP_POP,  16'h0000, 3'd0, 5'd1,  1'b1, '{STAT_POPPED,    16'h0000, 3'd0, 5'd1}},
        '{OP_POP,  16'h0000, 3'd0, 5'd1,  1'b1, '{STAT_POPPED,    16'hA5A5, 3'd0, 5'd0}},
        '{OP_POP,  16'h0000, 3'd0, 5'd1,  1'b1, '{STAT_EMPTY,     16'h0000, 3'd0, 5'd0}},
        '{OP_PUSH, 16'h1000, 3'd0, 5'd16, 1'b0, '{STAT_TICK_DONE, 16'h0000, 3'd0, 5'd0}},
        '{OP_PUSH, 16'h1234, 3'd5, 5'd1,  1'b1, '{STAT_FULL,      16'h0000, 3'd0, 5'd16}},
        '{OP_TICK, 16'h0000, 3'd0, 5'd1,  1'b1, '{STAT_TICK_DONE, 16'h0000, 3'd0, 5'd16}},
        '{OP_POP,  16'h0000, 3'd0, 5'd16, 1'b0, '{STAT_TICK_DONE, 16'h0000, 3'd0, 5'd0}},
        '{OP_POP,  16'h0000, 3'd0, 5'd1,  1'b1, '{STAT_EMPTY,     16'h0000, 3'd0, 5'd0}}
    };

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 push         = 1'b0;
    logic                 full;
    op_t                  op           = OP_TICK;
    logic [TAG_W-1:0]     job_tag      = '0;
    logic [PRIO_W-1:0]    job_priority = '0;
    logic                 empty;
    logic                 pop          = 1'b0;
    logic [2:0]           status;
    logic [TAG_W-1:0]     out_tag;
    logic [PRIO_W-1:0]    out_priority;
    logic [FILL_W-1:0]    fill_count;
    logic                 cfg_we       = 1'b0;
    cfg_idx_t             cfg_index    = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // side channel carrying a hand-written reply along with the word
    logic                 word_fixed   = 1'b0;
    res_t                 word_reply   = '0;

    // shadow of the queue
    logic [TAG_W-1:0]     held_tag   [QUEUE_DEPTH];
    logic [PRIO_W-1:0]    held_prio  [QUEUE_DEPTH];
    logic [TIME_W-1:0]    held_stamp [QUEUE_DEPTH];
    int                   held_count   = 0;
    logic [TIME_W-1:0]    clock_now    = '0;
    logic [TIME_W-1:0]    aging_after  = THRESHOLD_RESET;
    logic [PRIO_W-1:0]    free_code    = FREE_RESET;
    logic [PRIO_W-1:0]    premium_code = PREMIUM_RESET;

    res_t                 awaited_replies [$];

    int sender_idle   = 0;
    int recv_idle     = 0;
    bit hold_request  = 1'b0;
    int failures      = 0;
    int words_in      = 0;
    int replies_seen  = 0;
    int full_rejects  = 0;
    int empty_pops    = 0;
    int aged_picks    = 0;
    int stall_cycles  = 0;
    int quiet_cycles  = 0;

    aging_priority_queue uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .op           (op),
        .job_tag      (job_tag),
        .job_priority (job_priority),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .out_tag      (out_tag),
        .out_priority (out_priority),
        .fill_count   (fill_count),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [PRIO_W-1:0] rank_of(int i);
        logic [TIME_W-1:0] age;
        age = clock_now - held_stamp[i];
        if (held_prio[i] == free_code && age >= aging_after)
            return premium_code;
        return held_prio[i];
    endfunction

    function automatic res_t reply_for(op_t o, logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio);
        res_t              r;
        int                best;
        logic [PRIO_W-1:0] best_code;
        r = '0;
        case (o)
            OP_TICK:
            begin
                clock_now = clock_now + 1'b1;
                r.status = STAT_TICK_DONE;
            end
            OP_PUSH:
            begin
                if (held_count >= QUEUE_DEPTH)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    held_tag[held_count]   = tag;
                    held_prio[held_count]  = prio;
                    held_stamp[held_count] = clock_now;
                    held_count++;
                    r.status = STAT_PUSHED;
                end
            end
            OP_POP:
            begin
                if (held_count == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    best = 0;
                    best_code = rank_of(0);
                    for (int i = 1; i < held_count; i++)
                    begin
                        if (rank_of(i) > best_code)
                        begin
                            best = i;
                            best_code = rank_of(i);
                        end
                    end
                    if (best_code != held_prio[best])
                        aged_picks++;
                    r.status = STAT_POPPED;
                    r.tag    = held_tag[best];
                    r.prio   = held_prio[best];
                    for (int i = best; i + 1 < held_count; i++)
                    begin
                        held_tag[i]   = held_tag[i + 1];
                        held_prio[i]  = held_prio[i + 1];
                        held_stamp[i] = held_stamp[i + 1];
                    end
                    held_count--;
                end
            end
            default:
            begin
                r.status = STAT_TICK_DONE;
            end
        endcase
        r.fill = FILL_W'(held_count);
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        res_t predicted;
        res_t want;
        if (rst_n && cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD: aging_after  = cfg_data;
                CFG_FREE:      free_code    = cfg_data[PRIO_W-1:0];
                CFG_PREMIUM:   premium_code = cfg_data[PRIO_W-1:0];
                default: ;
            endcase
        end
        if (rst_n && push && !full)
        begin
            predicted = reply_for(op, job_tag, job_priority);
            awaited_replies.insert(awaited_replies.size(), word_fixed ? word_reply : predicted);
            words_in++;
        end
        if (rst_n && push && full)
            stall_cycles++;
        if (rst_n && pop && !empty)
        begin
            replies_seen++;
            if (awaited_replies.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result word: status %0d tag %h prio %0d fill %0d",
                             status, out_tag, out_priority, fill_count);
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (want.status == STAT_FULL)
                    full_rejects++;
                if (want.status == STAT_EMPTY)
                    empty_pops++;
                if (status !== want.status || out_tag !== want.tag ||
                    out_priority !== want.prio || fill_count !== want.fill)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("mismatch at reply %0d: want status %0d tag %h prio %0d fill %0d",
                                 replies_seen, want.status, want.tag, want.prio, want.fill);
                        $display("    got status %0d tag %h prio %0d fill %0d",
                                 status, out_tag, out_priority, fill_count);
                    end
                end
            end
        end
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no word moved for %0d cycles, %0d replies outstanding",
                     quiet_cycles, awaited_replies.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                pop <= 1'b0;
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pop <= ($urandom_range(99) >= recv_idle);
                @(posedge clk);
            end
        end
    end

    task automatic send_word(op_t o, logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio,
                             logic fixed, res_t reply);
        while ($urandom_range(99) < sender_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        op           <= o;
        job_tag      <= tag;
        job_priority <= prio;
        word_fixed   <= fixed;
        word_reply   <= reply;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic drain_replies();
        do
            @(posedge clk);
        while (awaited_replies.size() != 0);
    endtask

    initial
    begin
        int          bias;
        int          roll;
        op_t         kind;
        logic [PRIO_W-1:0] prio;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle = PHASE_SEND_IDLE[0];
        recv_idle   = PHASE_RECV_IDLE[0];
        for (int r = 0; r < PLAN_ROWS; r++)
            for (int k = 0; k < PLAN[r].reps; k++)
                send_word(PLAN[r].kind, PLAN[r].tag + TAG_W'(k), PLAN[r].prio + PRIO_W'(k),
                          PLAN[r].fixed, PLAN[r].reply);
        push <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_replies();
            repeat (4) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_THRESHOLD;
            cfg_data  <= PHASE_THRESHOLD[ph];
            @(posedge clk);
            cfg_index <= CFG_FREE;
            cfg_data  <= CFG_DATA_W'(PHASE_FREE[ph]);
            @(posedge clk);
            cfg_index <= CFG_PREMIUM;
            cfg_data  <= CFG_DATA_W'(PHASE_PREMIUM[ph]);
            @(posedge clk);
            cfg_we <= 1'b0;
            sender_idle = PHASE_SEND_IDLE[ph];
            recv_idle   = PHASE_RECV_IDLE[ph];
            if (ph == 0 || ph == 4)
                hold_request = 1'b1;
            bias = 0;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // bursts that lean towards filling or draining the queue
                if (n % 40 == 0)
                    bias = $urandom_range(2);
                roll = $urandom_range(99);
                if (roll < (bias == 1 ? 65 : bias == 2 ? 25 : 45))
                    kind = OP_PUSH;
                else if (roll < (bias == 2 ? 75 : 80))
                    kind = OP_POP;
                else if (roll < 97)
                    kind = OP_TICK;
                else
                    kind = OP_NONE;
                prio = ($urandom_range(99) < 40) ? PHASE_FREE[ph] : PRIO_W'($urandom_range(7));
                send_word(kind, TAG_W'($urandom_range(16'hFFFF)), prio, 1'b0, '0);
            end
            push <= 1'b0;
        end

        drain_replies();
        repeat (20) @(posedge clk);
        $display("covered %0d words in, %0d replies, %0d full rejects, %0d pops on empty",
                 words_in, replies_seen, full_rejects, empty_pops);
        $display("%0d pops won by aged jobs, input stalled %0d cycles, %0d failures",
                 aged_picks, stall_cycles, failures);
        if (failures == 0 && awaited_replies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
design/apq_pkg.sv
design/apq_front.sv
design/apq_back.sv
design/apq_res_fifo.sv
design/aging_priority_queue.sv
test/aging_priority_queue_test.sv
